// ----- design/assert_macros.svh -----
// Assertion macros shared by the display core modules.
// All modules clock on i_clk and reset on i_rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, muted while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked property, also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- design/mcad_pkg.sv -----
// Shared types, constants and helper functions for the clock/alarm display core.
// No dependencies.
package mcad_pkg;

    localparam int CfgDataW = 6;
    localparam int CfgIdxW  = 2;

    typedef enum logic [CfgIdxW-1:0] {
        CfgAlarmEnable = 2'd0,
        CfgAlarmHour   = 2'd1,
        CfgAlarmMinute = 2'd2
    } t_cfg_idx;

    localparam logic [5:0] DecRadix    = 6'd10;
    localparam logic [2:0] LastDigit   = 3'd7;
    localparam logic [2:0] WeekendFrom = 3'd4;  // weekday above this is weekend

    // Segment patterns for digits 0..9, bit k is segment column k.
    localparam logic [6:0] SegTable [10] = '{
        7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
    };

    // One queued sample, everything the scan side needs.
    typedef struct packed {
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       armed;
        logic       weekend;
        logic       music;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Tens digit by reciprocal multiply, exact for 0..63.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [12:0] p;
        p = 13'(v) * 13'd13;
        return p[10:7];
    endfunction

    // Blank for anything above nine.
    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        s = 7'd0;
        if (d <= 4'd9) begin
            s = SegTable[d];
        end
        return s;
    endfunction

endpackage

// ----- design/multiplexed_clock_alarm_display_core.sv -----
// Top level of the multiplexed clock/alarm seven-segment display core.
// Depends on mcad_pkg, mcad_front, mcad_fifo and mcad_back.
//
// Use:
//   Input channel (i_valid / o_stall): one time sample per transfer - hour,
//   minute, weekday and a stop_music bit that clears the alarm latch before
//   the alarm check. The sample's alarm check is done at transfer.
//   Output channel (o_valid / i_stall): eight transfers per sample, digit 1
//   first. Digits 1-4 show current HH:MM, digits 5-8 the alarm HH:MM;
//   o_last_digit marks the eighth. LEDs carry armed, weekend and music.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data): 0 alarm enable,
//   1 alarm hour, 2 alarm minute; index 3 is ignored. Write while idle.
// Timing:
//   The transfer edge writes the queue; the back end loads digit 1 from
//   its head once free. Throughput is one result per cycle while the
//   queue holds a sample and i_stall is low, paced by the single digit
//   scan counter in the back end. The queue (QUEUE_DEPTH samples) lets
//   the front take new samples while a scan is under way.
// Reset: queue empty, scan at digit 1, music latch and config registers cleared.
// Stall: a stalled result holds in the output register; the queue fills,
//   and then o_stall goes high toward the sample source.
module multiplexed_clock_alarm_display_core import mcad_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [4:0]          i_now_hour,
    input  logic [5:0]          i_now_minute,
    input  logic [2:0]          i_weekday,
    input  logic                i_stop_music,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_digit_select_n,
    output logic [6:0]          o_segments,
    output logic                o_decimal_point,
    output logic                o_led_armed,
    output logic                o_led_weekend,
    output logic                o_led_chime,
    output logic                o_last_digit
);

    t_rec    push_rec;
    t_rec    head_rec;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // Front: config, accept, alarm match, music latch.
    mcad_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_now_hour   (i_now_hour),
        .i_now_minute (i_now_minute),
        .i_weekday    (i_weekday),
        .i_stop_music (i_stop_music),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    // Sample queue; each entry carries a snapshot of the alarm time too.
    mcad_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_rec),
        .i_pop   (pop),
        .o_rdata (head_rec),
        .o_stat  (q_stat)
    );

    // Back: digit scan, segment decode, output register.
    mcad_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec            (head_rec),
        .i_q_stat         (q_stat),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digit_select_n (o_digit_select_n),
        .o_segments       (o_segments),
        .o_decimal_point  (o_decimal_point),
        .o_led_armed      (o_led_armed),
        .o_led_weekend    (o_led_weekend),
        .o_led_chime      (o_led_chime),
        .o_last_digit     (o_last_digit)
    );

endmodule

// ----- design/mcad_front.sv -----
// Front end: config registers, sample accept, alarm check and music latch.
// Depends on mcad_pkg; feeds mcad_fifo.
module mcad_front import mcad_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [4:0]          i_now_hour,
    input  logic [5:0]          i_now_minute,
    input  logic [2:0]          i_weekday,
    input  logic                i_stop_music,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output t_rec                o_rec
);

    logic       r_alarm_enable;
    logic [4:0] r_alarm_hour;
    logic [5:0] r_alarm_minute;
    logic       r_music;
    logic       n_music;
    logic       match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_enable <= 1'b0;
            r_alarm_hour   <= 5'd0;
            r_alarm_minute <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CfgAlarmEnable: r_alarm_enable <= i_cfg_data[0];
                CfgAlarmHour:   r_alarm_hour   <= i_cfg_data[4:0];
                CfgAlarmMinute: r_alarm_minute <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    // Clear first, then a match sets the latch again.
    assign match   = r_alarm_enable && (i_now_hour == r_alarm_hour)
                     && (i_now_minute == r_alarm_minute);
    assign n_music = (r_music && !i_stop_music) || match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_music <= 1'b0;
        end else if (o_push) begin
            r_music <= n_music;
        end
    end

    always_comb begin
        o_rec.now_hour     = i_now_hour;
        o_rec.now_minute   = i_now_minute;
        o_rec.alarm_hour   = r_alarm_hour;
        o_rec.alarm_minute = r_alarm_minute;
        o_rec.armed        = r_alarm_enable;
        o_rec.weekend      = i_weekday > WeekendFrom;
        o_rec.music        = n_music;
    end

endmodule

// ----- design/mcad_fifo.sv -----
// Short sample queue between front end and scan back end.
// Depends on mcad_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mcad_fifo import mcad_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_rec    i_wdata,
    input  logic    i_pop,
    output t_rec    o_rdata,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = r_count == CW'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_rdata      = r_mem[r_rd_ptr];

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = p + 1'b1;
        if (p == AW'(DEPTH - 1)) begin
            q = '0;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_count_bound, r_count <= CW'(DEPTH), "queue count above depth")
    `ASSERT_CLK(a_no_push_full, o_stat.full |-> !i_push, "push into full queue")
    `ASSERT_CLK(a_no_pop_empty, o_stat.empty |-> !i_pop, "pop from empty queue")

endmodule

// ----- design/mcad_back.sv -----
// Scan back end: walks eight digits per queued sample into an output register.
// Depends on mcad_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mcad_back import mcad_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rec       i_rec,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_digit_select_n,
    output logic [6:0] o_segments,
    output logic       o_decimal_point,
    output logic       o_led_armed,
    output logic       o_led_weekend,
    output logic       o_led_chime,
    output logic       o_last_digit
);

    logic [2:0] r_digit;
    logic       r_valid;
    logic [7:0] r_sel_n;
    logic [6:0] r_seg;
    logic       r_dp;
    logic       r_armed;
    logic       r_weekend;
    logic       r_music;
    logic       r_last;

    logic       load;
    logic [5:0] value;
    logic [3:0] tens;
    logic [5:0] units;
    logic [3:0] digit;

    assign load  = !i_q_stat.empty && (!r_valid || !i_stall);
    assign o_pop = load && (r_digit == LastDigit);

    always_comb begin
        unique case (r_digit[2:1])
            2'd0: value = {1'b0, i_rec.now_hour};
            2'd1: value = i_rec.now_minute;
            2'd2: value = {1'b0, i_rec.alarm_hour};
            default: value = i_rec.alarm_minute;
        endcase
        tens  = tens_of(value);
        units = value - ({2'b00, tens} * DecRadix);
        digit = r_digit[0] ? units[3:0] : tens;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_digit <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_digit <= r_digit + 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sel_n   <= ~(8'd1 << r_digit);
            r_seg     <= seg_of(digit);
            r_dp      <= r_digit[1:0] == 2'b01;
            r_armed   <= i_rec.armed;
            r_weekend <= i_rec.weekend;
            r_music   <= i_rec.music;
            r_last    <= r_digit == LastDigit;
        end
    end

    assign o_valid          = r_valid;
    assign o_digit_select_n = r_sel_n;
    assign o_segments       = r_seg;
    assign o_decimal_point  = r_dp;
    assign o_led_armed      = r_armed;
    assign o_led_weekend    = r_weekend;
    assign o_led_chime      = r_music;
    assign o_last_digit     = r_last;

    `ASSERT_CLK(a_sel_onehot, r_valid |-> $onehot(~r_sel_n), "digit select not one-hot")
    `ASSERT_CLK(a_last_sel, (r_valid && r_last) |-> (r_sel_n == 8'h7F),
        "last flag off the eighth digit")
    `ASSERT_CLK(a_held, (r_valid && i_stall) |=> (r_valid && $stable(r_digit)),
        "scan advanced while stalled")

endmodule

// ----- verif/multiplexed_clock_alarm_display_core_tb.sv -----
// Self-checking testbench for the multiplexed clock/alarm display core.
// Depends on mcad_pkg and multiplexed_clock_alarm_display_core; scoreboard
// predicts the eight digit scans of every accepted time sample.
module multiplexed_clock_alarm_display_core_tb import mcad_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 of the config port decodes to nothing.
    localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
    localparam int NumDigits   = 8;
    localparam int PhaseItems  = 75;
    localparam int NumPhases   = 6;
    localparam int DrainCycles = 4;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
        logic       stop;
    } t_sample;

    typedef struct packed {
        logic [7:0] digit_select_n;
        logic [6:0] segments;
        logic       decimal_point;
        logic       led_armed;
        logic       led_weekend;
        logic       led_chime;
        logic       last_digit;
    } t_scan;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx    = '0;
    logic [CfgDataW-1:0] i_cfg_data   = '0;
    logic                i_valid      = 1'b0;
    logic                o_stall;
    logic [4:0]          i_now_hour   = '0;
    logic [5:0]          i_now_minute = '0;
    logic [2:0]          i_weekday    = '0;
    logic                i_stop_music = 1'b0;
    logic                o_valid;
    logic                i_stall      = 1'b0;
    logic [7:0]          o_digit_select_n;
    logic [6:0]          o_segments;
    logic                o_decimal_point;
    logic                o_led_armed;
    logic                o_led_weekend;
    logic                o_led_chime;
    logic                o_last_digit;

    // Samples waiting to be driven, scans waiting to be seen.
    t_sample sample_q[$];
    t_scan   scan_q[$];

    // Mirror of the alarm registers and the music latch.
    logic       alarm_on    = 1'b0;
    logic [4:0] alarm_hh    = '0;
    logic [5:0] alarm_mm    = '0;
    logic       music_on    = 1'b0;

    // Idle knobs, percent per transfer (source) and per cycle (sink).
    int      src_idle_pct = 0;
    int      snk_idle_pct = 0;
    int      src_gap      = 0;
    int      snk_hold     = 0;
    int      mismatches   = 0;
    t_sample cur_sample;

    always #5 i_clk = ~i_clk;

    multiplexed_clock_alarm_display_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_now_hour       (i_now_hour),
        .i_now_minute     (i_now_minute),
        .i_weekday        (i_weekday),
        .i_stop_music     (i_stop_music),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digit_select_n (o_digit_select_n),
        .o_segments       (o_segments),
        .o_decimal_point  (o_decimal_point),
        .o_led_armed      (o_led_armed),
        .o_led_weekend    (o_led_weekend),
        .o_led_chime      (o_led_chime),
        .o_last_digit     (o_last_digit)
    );

    // Seven-segment pattern; anything above nine is dark.
    function automatic logic [6:0] digit_segments(input int d);
        logic [6:0] pat;
        case (d)
            0: pat = 7'h77;
            1: pat = 7'h24;
            2: pat = 7'h5D;
            3: pat = 7'h6D;
            4: pat = 7'h2E;
            5: pat = 7'h6B;
            6: pat = 7'h7B;
            7: pat = 7'h25;
            8: pat = 7'h7F;
            9: pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

    // Alarm check for one sample, then its eight scans, digit 1 first.
    // Clear goes before the match, so clear plus match leaves the latch set.
    task automatic predict_scan(input t_sample s);
        int    shown [4];
        int    v;
        int    d;
        t_scan r;
        if (s.stop) begin
            music_on = 1'b0;
        end
        if (alarm_on && s.hour == alarm_hh && s.minute == alarm_mm) begin
            music_on = 1'b1;
        end
        shown[0] = s.hour;
        shown[1] = s.minute;
        shown[2] = alarm_hh;
        shown[3] = alarm_mm;
        for (int k = 0; k < NumDigits; k++) begin
            v = shown[k >> 1];
            d = (k % 2 == 1) ? (v % 10) : (v / 10);
            r.digit_select_n = ~(8'b1 << k);
            r.segments       = digit_segments(d);
            r.decimal_point  = (k == 1 || k == 5);
            r.led_armed      = alarm_on;
            r.led_weekend    = (s.weekday > 3'd4);
            r.led_chime      = music_on;
            r.last_digit     = (k == NumDigits - 1);
            scan_q.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Source side: one transfer per accepted sample, payload held while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_scan(cur_sample);
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    i_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    cur_sample = sample_q.pop_front();
                    i_now_hour   <= cur_sample.hour;
                    i_now_minute <= cur_sample.minute;
                    i_weekday    <= cur_sample.weekday;
                    i_stop_music <= cur_sample.stop;
                    i_valid      <= 1'b1;
                    if ($urandom_range(99) < src_idle_pct) begin
                        src_gap = $urandom_range(14, 1);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: compare each result transfer, stall in bursts.
    always @(posedge i_clk) begin
        t_scan want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (scan_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end else begin
                    want = scan_q.pop_front();
                    check_field("digit_select_n", want.digit_select_n, o_digit_select_n);
                    check_field("segments", 8'(want.segments), 8'(o_segments));
                    check_field("decimal_point", 8'(want.decimal_point), 8'(o_decimal_point));
                    check_field("led_armed", 8'(want.led_armed), 8'(o_led_armed));
                    check_field("led_weekend", 8'(want.led_weekend), 8'(o_led_weekend));
                    check_field("led_chime", 8'(want.led_chime), 8'(o_led_chime));
                    check_field("last_digit", 8'(want.last_digit), 8'(o_last_digit));
                end
            end
            if (snk_hold > 0) begin
                snk_hold = snk_hold - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(99) < snk_idle_pct) begin
                snk_hold = $urandom_range(13, 0);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CfgAlarmEnable: alarm_on = data[0];
            CfgAlarmHour:   alarm_hh = data[4:0];
            CfgAlarmMinute: alarm_mm = data[5:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input int hh, input int mm, input int wd, input bit stop);
        t_sample s;
        s.hour    = 5'(hh);
        s.minute  = 6'(mm);
        s.weekday = 3'(wd);
        s.stop    = stop;
        sample_q.push_back(s);
    endtask

    // Block is idle once every queued sample went in and all scans came out.
    task automatic drain();
        while (sample_q.size() != 0 || i_valid || scan_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Random sample; about a third hit the alarm time so the latch gets exercised.
    function automatic t_sample rand_sample();
        t_sample s;
        if ($urandom_range(99) < 30) begin
            s.hour   = alarm_hh;
            s.minute = alarm_mm;
        end else begin
            s.hour   = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 24))
                                                : 5'($urandom_range(23, 0));
            s.minute = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 60))
                                                : 6'($urandom_range(59, 0));
        end
        s.weekday = 3'($urandom_range(7, 0));
        s.stop    = ($urandom_range(3) == 0);
        return s;
    endfunction

    initial begin
        int pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 20;
        snk_idle_pct = 5;

        // Registers at reset: alarm off, so 00:00 must not fire.
        add_sample(0, 0, 0, 0);
        add_sample(23, 59, 6, 0);
        add_sample(31, 63, 7, 1);
        add_sample(24, 60, 5, 0);
        add_sample(12, 34, 4, 1);
        add_sample(9, 9, 1, 0);
        add_sample(10, 10, 2, 0);
        add_sample(19, 45, 3, 1);
        drain();

        // Armed at 07:30: fire, hold, clear, clear plus match, match again, clear.
        write_reg(CfgAlarmEnable, 6'd1);
        write_reg(CfgAlarmHour, 6'd7);
        write_reg(CfgAlarmMinute, 6'd30);
        add_sample(7, 30, 1, 0);
        add_sample(7, 31, 1, 0);
        add_sample(8, 0, 2, 1);
        add_sample(7, 30, 3, 1);
        add_sample(7, 30, 5, 0);
        add_sample(0, 0, 0, 1);
        drain();

        // Unused index must leave the alarm time alone.
        write_reg(CfgIdxUnused, 6'h3F);
        add_sample(7, 30, 2, 0);
        drain();

        write_reg(CfgAlarmHour, 6'd23);
        write_reg(CfgAlarmMinute, 6'd59);
        add_sample(23, 59, 6, 1);
        add_sample(23, 58, 0, 0);
        drain();

        // Upper data bit on the hour register is dropped: 6'h3F reads as 31.
        write_reg(CfgAlarmHour, 6'h3F);
        write_reg(CfgAlarmMinute, 6'h3F);
        add_sample(31, 63, 7, 0);
        drain();

        // Disarmed: no new match, clear still works.
        write_reg(CfgAlarmEnable, 6'd0);
        add_sample(31, 63, 7, 1);
        drain();

        write_reg(CfgAlarmEnable, 6'd1);
        write_reg(CfgAlarmHour, 6'd0);
        write_reg(CfgAlarmMinute, 6'd0);
        add_sample(0, 0, 0, 0);
        drain();

        // Random phases, fresh alarm settings each; the last runs without idling.
        for (int p = 0; p < NumPhases; p++) begin
            write_reg(CfgAlarmEnable, 6'($urandom_range(1)));
            pick = ($urandom_range(7) == 0) ? $urandom_range(31, 24) : $urandom_range(23, 0);
            write_reg(CfgAlarmHour, {1'($urandom_range(1)), 5'(pick)});
            write_reg(CfgAlarmMinute, 6'($urandom_range(63)));
            if (p == NumPhases - 1) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                case ($urandom_range(3))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 15;
                    2: src_idle_pct = 40;
                    default: src_idle_pct = 70;
                endcase
                case ($urandom_range(3))
                    0: snk_idle_pct = 0;
                    1: snk_idle_pct = 4;
                    2: snk_idle_pct = 10;
                    default: snk_idle_pct = 25;
                endcase
            end
            for (int n = 0; n < PhaseItems; n++) begin
                sample_q.push_back(rand_sample());
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("multiplexed_clock_alarm_display_core_tb passed");
        end else begin
            $display("multiplexed_clock_alarm_display_core_tb failed");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("multiplexed_clock_alarm_display_core_tb failed");
        $finish;
    end

endmodule
